// ===== sv/scaffold_gap_splitter_assert.svh =====
// Assertion macros shared by the splitter modules. Each module that uses
// them provides signals named clk and rst_n.
`ifndef SCAFFOLD_GAP_SPLITTER_ASSERT_SVH
`define SCAFFOLD_GAP_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("splitter assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("splitter assertion failed: next-cycle implication");

`endif

// ===== sv/sgs_pkg.sv =====
package sgs_pkg;

    // Width of a reported segment length and of the threshold register.
    localparam int OUT_LEN_W = 32;

    // Most segments one character can close.
    localparam int SLOTS = 3;
    localparam int SLOT_CNT_W = 2;

    // Bundles buffered between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OUT_LEN_W-1:0] GAP_THRESHOLD_RESET = 32'd20;

    // Register index, taken from bit 2 of the byte address.
    localparam logic REG_GAP_THRESHOLD = 1'b0;

    typedef enum logic {
        KIND_CONTIG = 1'b0,
        KIND_GAP    = 1'b1
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t            kind;
        logic [OUT_LEN_W-1:0] length;
        logic                 last;
    } seg_t;

    // All segments produced by one accepted character, oldest in slot 0.
    typedef struct packed {
        logic [SLOT_CNT_W-1:0] count;
        seg_t [SLOTS-1:0]      slot;
    } bundle_t;

    // Queue head as seen by the back part.
    typedef struct packed {
        logic    valid;
        bundle_t data;
    } queue_head_t;

    function automatic logic is_acgt(input logic [7:0] c);
        logic hit;
        begin
            case (c) inside
                8'h41, 8'h43, 8'h47, 8'h54,
                8'h61, 8'h63, 8'h67, 8'h74: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

// ===== sv/sgs_front.sv =====
`include "scaffold_gap_splitter_assert.svh"

module sgs_front #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [7:0]                      base,
    input  logic                            last_base,
    input  logic [sgs_pkg::OUT_LEN_W-1:0]   gap_threshold,
    output logic                            bundle_push,
    output sgs_pkg::bundle_t                bundle
);

    localparam int LW   = LENGTH_WIDTH;
    localparam int MAXW = (LW > sgs_pkg::OUT_LEN_W) ? LW : sgs_pkg::OUT_LEN_W;
    localparam int SUMW = LW + 2;
    localparam logic [LW-1:0] CNT_MAX = {LW{1'b1}};

    logic          in_gap_run_reg, in_gap_run_next;
    logic [LW-1:0] gap_run_length_reg, gap_run_length_next;
    logic [LW-1:0] contig_length_reg, contig_length_next;

    logic [SUMW-1:0]                  merge_sum;
    logic [SUMW-1:0]                  contig_inc;
    logic [SUMW-1:0]                  gap_inc;
    logic                             run_splits;
    sgs_pkg::bundle_t                 bundle_c;
    logic [sgs_pkg::SLOT_CNT_W-1:0]   n;

    function automatic logic [sgs_pkg::OUT_LEN_W-1:0] clamp_out(input logic [LW-1:0] v);
        logic [MAXW-1:0] wide;
        begin
            wide = MAXW'(v);
            if (wide > MAXW'({sgs_pkg::OUT_LEN_W{1'b1}}))
                return {sgs_pkg::OUT_LEN_W{1'b1}};
            return wide[sgs_pkg::OUT_LEN_W-1:0];
        end
    endfunction

    function automatic logic [LW-1:0] sat(input logic [SUMW-1:0] s);
        begin
            if (s > SUMW'(CNT_MAX))
                return CNT_MAX;
            return s[LW-1:0];
        end
    endfunction

    assign merge_sum  = SUMW'(contig_length_reg) + SUMW'(gap_run_length_reg) + SUMW'(1);
    assign contig_inc = SUMW'(contig_length_reg) + SUMW'(1);
    assign gap_inc    = SUMW'(gap_run_length_reg) + SUMW'(1);
    assign run_splits = (contig_length_reg == '0) ||
                        (MAXW'(gap_run_length_reg) >= MAXW'(gap_threshold));

    always_comb
    begin
        in_gap_run_next     = in_gap_run_reg;
        gap_run_length_next = gap_run_length_reg;
        contig_length_next  = contig_length_reg;
        bundle_c            = '0;
        n                   = '0;

        if (sgs_pkg::is_acgt(base))
        begin
            if (in_gap_run_reg)
            begin
                if (run_splits)
                begin
                    if (contig_length_reg != '0)
                    begin
                        bundle_c.slot[n].kind   = sgs_pkg::KIND_CONTIG;
                        bundle_c.slot[n].length = clamp_out(contig_length_reg);
                        n = n + 1'b1;
                    end
                    bundle_c.slot[n].kind   = sgs_pkg::KIND_GAP;
                    bundle_c.slot[n].length = clamp_out(gap_run_length_reg);
                    n = n + 1'b1;
                    contig_length_next = LW'(1);
                end
                else
                begin
                    contig_length_next = sat(merge_sum);
                end
                in_gap_run_next     = 1'b0;
                gap_run_length_next = '0;
            end
            else
            begin
                contig_length_next = sat(contig_inc);
            end
        end
        else
        begin
            in_gap_run_next     = 1'b1;
            gap_run_length_next = sat(gap_inc);
        end

        if (last_base)
        begin
            if (contig_length_next != '0)
            begin
                bundle_c.slot[n].kind   = sgs_pkg::KIND_CONTIG;
                bundle_c.slot[n].length = clamp_out(contig_length_next);
                n = n + 1'b1;
            end
            if (in_gap_run_next)
            begin
                bundle_c.slot[n].kind   = sgs_pkg::KIND_GAP;
                bundle_c.slot[n].length = clamp_out(gap_run_length_next);
                n = n + 1'b1;
            end
            if (n != '0)
                bundle_c.slot[n - 1'b1].last = 1'b1;
            in_gap_run_next     = 1'b0;
            gap_run_length_next = '0;
            contig_length_next  = '0;
        end

        bundle_c.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_gap_run_reg     <= 1'b0;
            gap_run_length_reg <= '0;
            contig_length_reg  <= '0;
        end
        else if (accept)
        begin
            in_gap_run_reg     <= in_gap_run_next;
            gap_run_length_reg <= gap_run_length_next;
            contig_length_reg  <= contig_length_next;
        end
    end

    assign bundle_push = accept && (bundle_c.count != '0);
    assign bundle      = bundle_c;

    // A run length is only carried while a run is open.
    `SGS_ASSERT_IMP(a_run_len_idle, !in_gap_run_reg, gap_run_length_reg == '0)
    // An open run always holds at least one character.
    `SGS_ASSERT_IMP(a_run_len_open, in_gap_run_reg, gap_run_length_reg != '0)

endmodule

// ===== sv/sgs_queue.sv =====
`include "scaffold_gap_splitter_assert.svh"

module sgs_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sgs_pkg::bundle_t      push_data,
    input  logic                  take,
    output logic                  full,
    output sgs_pkg::queue_head_t  head
);

    localparam int PW = sgs_pkg::QUEUE_PTR_W;
    localparam int CW = sgs_pkg::QUEUE_CNT_W;

    sgs_pkg::bundle_t store_reg [sgs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_take;

    assign do_take = take && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(sgs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_take)
            rd_ptr_next = (rd_ptr_reg == PW'(sgs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_take)
            count_next = count_reg + 1'b1;
        else if (!push && do_take)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    assign full       = (count_reg == CW'(sgs_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.data  = store_reg[rd_ptr_reg];

    `SGS_ASSERT_IMP(a_queue_bound, 1'b1, count_reg <= CW'(sgs_pkg::QUEUE_DEPTH))
    `SGS_ASSERT_NEXT(a_queue_push, push && !do_take, count_reg != '0)

endmodule

// ===== sv/sgs_back.sv =====
`include "scaffold_gap_splitter_assert.svh"

module sgs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sgs_pkg::queue_head_t            head,
    output logic                            take,
    input  logic                            pop,
    output logic                            empty,
    output logic                            segment_kind,
    output logic [sgs_pkg::OUT_LEN_W-1:0]   segment_length,
    output logic                            last_segment
);

    localparam int SW = sgs_pkg::SLOT_CNT_W;

    sgs_pkg::bundle_t cur_reg, cur_next;
    logic [SW-1:0]    idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic             out_xfer;
    logic             at_end;
    sgs_pkg::seg_t    seg;

    assign out_xfer = pop && valid_reg;
    assign at_end   = (idx_reg == cur_reg.count - 1'b1);
    assign take     = head.valid && (!valid_reg || (out_xfer && at_end));

    always_comb
    begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (take)
        begin
            cur_next   = head.data;
            idx_next   = '0;
            valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            if (at_end)
            begin
                valid_next = 1'b0;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign seg            = cur_reg.slot[idx_reg];
    assign empty          = !valid_reg;
    assign segment_kind   = seg.kind;
    assign segment_length = seg.length;
    assign last_segment   = seg.last;

    // The slot index never runs past the bundle it walks.
    `SGS_ASSERT_IMP(a_idx_in_bundle, valid_reg, idx_reg < cur_reg.count)

endmodule

// ===== sv/scaffold_gap_splitter.sv =====
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+----------------------------------------
// input     | in        | push / full           | base, last_base
// results   | out       | pop / empty           | segment_kind, segment_length, last_segment
// config    | in        | psel, penable, pready | paddr, pwrite, pwdata, prdata
//
// One character is taken per cycle while full is low; the front updates its run counters in
// the cycle of the transfer and files every segment it closes as one bundle in a four-entry
// queue. The back hands out one segment per cycle while pop is high, so a character that
// closes k segments costs k result transfers; the result port, not the classifier, sets the
// long-run rate. Reset (rst_n low, asynchronous) clears the counters, the queue and the back
// part, and loads the gap threshold with 20.
// full rises only when the queue holds four bundles; a stalled result side then holds
// off new characters while earlier segments are still waiting to be taken.

module scaffold_gap_splitter #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      base,
    input  logic                            last_base,

    output logic                            empty,
    input  logic                            pop,
    output logic                            segment_kind,
    output logic [sgs_pkg::OUT_LEN_W-1:0]   segment_length,
    output logic                            last_segment,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic                          accept;
    logic                          cfg_write;
    logic [sgs_pkg::OUT_LEN_W-1:0] gap_threshold_reg;
    logic                          bundle_push;
    sgs_pkg::bundle_t              bundle;
    sgs_pkg::queue_head_t          head;
    logic                          take;

    // A character transfer happens whenever push is high and the queue has room.
    assign accept = push && !full;

    // The configuration port never waits. Bit 2 of the byte address picks the
    // register; the low two bits are the byte lane within it and are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_threshold_reg <= sgs_pkg::GAP_THRESHOLD_RESET;
        else if (cfg_write && (paddr[2] == sgs_pkg::REG_GAP_THRESHOLD))
            gap_threshold_reg <= pwdata;
    end

    assign prdata = (paddr[2] == sgs_pkg::REG_GAP_THRESHOLD) ? gap_threshold_reg : '0;

    // Front: classifies each character and closes contig and gap segments.
    sgs_front #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .base          (base),
        .last_base     (last_base),
        .gap_threshold (gap_threshold_reg),
        .bundle_push   (bundle_push),
        .bundle        (bundle)
    );

    // Queue between the two halves, so either may stall without the other.
    sgs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (bundle_push),
        .push_data (bundle),
        .take      (take),
        .full      (full),
        .head      (head)
    );

    // Back: walks a bundle and presents one segment per result transfer.
    sgs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .take           (take),
        .pop            (pop),
        .empty          (empty),
        .segment_kind   (segment_kind),
        .segment_length (segment_length),
        .last_segment   (last_segment)
    );

endmodule
